// File: sv/iakm_pkg.sv
// shared types and constants for the index allocator with key map
// no dependencies; used by every module of the block
package iakm_pkg;

  localparam int ENTRIES_DEF  = 256;
  localparam int KEY_BITS_DEF = 32;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REM_IDX = 3'd1;
  localparam logic [2:0] OP_REM_KEY = 3'd2;
  localparam logic [2:0] OP_KEY_OF  = 3'd3;
  localparam logic [2:0] OP_IDX_OF  = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] node_key;
    logic [7:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  index_out;
    logic [31:0] key_out;
  } rsp_t;

  typedef struct packed {
    logic set;
    logic drop;
    logic wipe;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_SEND
  } state_t;

endpackage

// File: sv/iakm_cell.sv
// one slot of the key map: stored key, in-use bit and registered key match
// depends on iakm_pkg
module iakm_cell #(
  parameter int KEY_BITS = iakm_pkg::KEY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  iakm_pkg::cell_ctrl_t   ctrl,
  input  logic [KEY_BITS-1:0]    key_in,
  output logic                   match,
  output logic                   valid
);

  logic [KEY_BITS-1:0] key;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.wipe) begin
      valid <= 1'b0;
    end else if (ctrl.set) begin
      valid <= 1'b1;
    end else if (ctrl.drop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.set) begin
      key <= key_in;
    end
    match <= valid && (key == key_in);
  end

endmodule

// File: sv/iakm_enc.sv
// turns the row of cell match bits into a hit flag and slot index
// depends on iakm_pkg only through the parameter defaults
module iakm_enc #(
  parameter int ENTRIES = iakm_pkg::ENTRIES_DEF,
  parameter int IW      = 8
) (
  input  logic [ENTRIES-1:0] match,
  output logic               found,
  output logic [IW-1:0]      idx
);

  // keys are unique, so at most one bit is set and an or of indices is exact
  always_comb begin
    idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        idx = idx | IW'(i);
      end
    end
    found = |match;
  end

endmodule

// File: sv/index_allocator_with_key_map.sv
// top level of the index allocator with key map
// depends on iakm_pkg, iakm_cell, iakm_enc
//
// usage:
//   request channel: req_valid / req_stall / req (operation, node_key,
//   slot_index). response channel: rsp_valid / rsp_stall / rsp (status,
//   index_out, key_out). every request gives exactly one response.
// sequence:
//   a request is taken in idle, then the look state does the cell compare and the
//   free stack / key memory reads, the exec state updates state and forms the
//   response, and the send state shows the response until it is taken.
//   no new request is taken until the response is taken; the registered
//   match in every cell and the read port of the free stack are why the
//   look state comes before exec.
// reset:
//   rst clears all in-use bits and both counts at once; no clearing pass.
// stall:
//   while rsp_stall is high the response holds and req_stall stays high.
module index_allocator_with_key_map #(
  parameter int ENTRIES  = iakm_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = iakm_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  iakm_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output iakm_pkg::rsp_t rsp
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = (IW > 8) ? IW : 8;

  iakm_pkg::state_t state, state_next;
  iakm_pkg::req_t   req_q;
  iakm_pkg::rsp_t   rsp_next;

  logic [CW-1:0] free_count, free_count_next;
  logic [CW-1:0] used_count, used_count_next;

  logic [IW-1:0]       fs_mem [ENTRIES];
  logic [KEY_BITS-1:0] km_mem [ENTRIES];
  logic [IW-1:0]       fs_rd;
  logic [KEY_BITS-1:0] km_rd;

  logic [63:0]         key_ext;
  logic [KEY_BITS-1:0] key_q;
  logic [SW-1:0]       sidx_w;
  logic [IW-1:0]       sidx;
  logic                sidx_ok;
  logic [CW-1:0]       fc_m1;
  logic [IW-1:0]       fs_top;

  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  logic               found;
  logic [IW-1:0]      found_idx;

  logic          exec;
  logic          set_en, drop_en, wipe_en, push_en;
  logic [IW-1:0] set_idx, drop_idx, res_idx;
  logic [KEY_BITS-1:0] res_key;
  logic [63:0]   res_key_w;
  logic          got;
  logic [IW-1:0] got_idx;

  iakm_pkg::cell_ctrl_t ctrl [ENTRIES];

  assign key_ext = 64'(req_q.node_key);
  assign key_q   = key_ext[KEY_BITS-1:0];
  assign sidx_w  = SW'(req_q.slot_index);
  assign sidx    = sidx_w[IW-1:0];
  assign sidx_ok = (32'(req_q.slot_index) < 32'(ENTRIES)) && valid_vec[sidx];
  assign fc_m1   = free_count - CW'(1);
  assign fs_top  = fc_m1[IW-1:0];
  assign exec    = (state == iakm_pkg::S_EXEC);

  // row of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign ctrl[i].set  = exec && set_en && (set_idx == IW'(i));
    assign ctrl[i].drop = exec && drop_en && (drop_idx == IW'(i));
    assign ctrl[i].wipe = exec && wipe_en;

    iakm_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl[i]),
      .key_in (key_q),
      .match  (match_vec[i]),
      .valid  (valid_vec[i])
    );
  end

  iakm_enc #(.ENTRIES(ENTRIES), .IW(IW)) u_enc (
    .match (match_vec),
    .found (found),
    .idx   (found_idx)
  );

  // free stack and index-to-key memory
  always_ff @(posedge clk) begin
    if (state == iakm_pkg::S_LOOK) begin
      fs_rd <= fs_mem[fs_top];
      km_rd <= km_mem[sidx];
    end
    if (exec && push_en) begin
      fs_mem[free_count[IW-1:0]] <= drop_idx;
    end
    if (exec && set_en) begin
      km_mem[set_idx] <= key_q;
    end
  end

  // request decode and state update
  always_comb begin
    set_en          = 1'b0;
    drop_en         = 1'b0;
    wipe_en         = 1'b0;
    push_en         = 1'b0;
    set_idx         = '0;
    drop_idx        = '0;
    res_idx         = '0;
    res_key         = '0;
    got             = 1'b0;
    got_idx         = '0;
    free_count_next = free_count;
    used_count_next = used_count;
    rsp_next        = '0;
    rsp_next.status = iakm_pkg::ST_NOT_FOUND;

    unique case (req_q.operation)
      iakm_pkg::OP_ADD: begin
        if (found) begin
          rsp_next.status = iakm_pkg::ST_OK;
          res_idx         = found_idx;
          res_key         = key_q;
        end else begin
          if (free_count != '0) begin
            got             = 1'b1;
            got_idx         = fs_rd;
            free_count_next = fc_m1;
          end else if (32'(used_count) < 32'(ENTRIES)) begin
            got     = 1'b1;
            got_idx = used_count[IW-1:0];
          end
          if (got) begin
            set_en          = 1'b1;
            set_idx         = got_idx;
            used_count_next = used_count + CW'(1);
            rsp_next.status = iakm_pkg::ST_OK;
            res_idx         = got_idx;
            res_key         = key_q;
          end else begin
            rsp_next.status = iakm_pkg::ST_FULL;
          end
        end
      end
      iakm_pkg::OP_REM_IDX, iakm_pkg::OP_KEY_OF: begin
        if (sidx_ok) begin
          rsp_next.status = iakm_pkg::ST_OK;
          res_idx         = sidx;
          res_key         = km_rd;
          drop_en         = (req_q.operation == iakm_pkg::OP_REM_IDX);
          drop_idx        = sidx;
        end
      end
      iakm_pkg::OP_REM_KEY, iakm_pkg::OP_IDX_OF: begin
        if (found) begin
          rsp_next.status = iakm_pkg::ST_OK;
          res_idx         = found_idx;
          res_key         = key_q;
          drop_en         = (req_q.operation == iakm_pkg::OP_REM_KEY);
          drop_idx        = found_idx;
        end
      end
      iakm_pkg::OP_CLEAR: begin
        wipe_en         = 1'b1;
        free_count_next = '0;
        used_count_next = '0;
        rsp_next.status = iakm_pkg::ST_OK;
      end
      default: begin
      end
    endcase

    // freeing a slot pushes its index
    if (drop_en) begin
      if (used_count != '0) begin
        used_count_next = used_count - CW'(1);
      end
      if (32'(free_count) < 32'(ENTRIES)) begin
        push_en         = 1'b1;
        free_count_next = free_count + CW'(1);
      end
    end

    res_key_w          = 64'(res_key);
    rsp_next.index_out = 8'(res_idx);
    rsp_next.key_out   = res_key_w[31:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      iakm_pkg::S_IDLE: if (req_valid) state_next = iakm_pkg::S_LOOK;
      iakm_pkg::S_LOOK: state_next = iakm_pkg::S_EXEC;
      iakm_pkg::S_EXEC: state_next = iakm_pkg::S_SEND;
      iakm_pkg::S_SEND: if (!rsp_stall) state_next = iakm_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req_stall = (state != iakm_pkg::S_IDLE);
    rsp_valid = (state == iakm_pkg::S_SEND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= iakm_pkg::S_IDLE;
      free_count <= '0;
      used_count <= '0;
    end else begin
      state <= state_next;
      if (exec) begin
        free_count <= free_count_next;
        used_count <= used_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    if (exec) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used_count) <= 32'(ENTRIES))
    else $error("used count beyond table size");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    32'(free_count) <= 32'(ENTRIES))
    else $error("free stack overflow");

  a_unique_key: assert property (@(posedge clk) disable iff (rst)
    exec |-> $onehot0(match_vec))
    else $error("key stored in more than one slot");

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == iakm_pkg::S_LOOK))
    else $error("request taken without lookup");

  a_add_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (exec && set_en) |=> valid_vec[$past(set_idx)])
    else $error("added slot not marked in use");
`endif

endmodule
